// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and the control store of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ADDR_BITS = 20;
    localparam int POOL_BITS = 20;
    localparam int CONS_BITS = ADDR_BITS + 1;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [POOL_BITS-1:0] t_pool;
    typedef logic [CONS_BITS-1:0] t_cons;

    localparam t_pool POOL_RESET = 20'd10240;

    // Register index of the pool size register
    localparam int REG_POOL = 0;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OOM       = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_START,
        C_FREE,
        C_ASTOP,
        C_FSTOP,
        C_END,
        C_ROOM
    } t_cond;

    // Datapath operations that finish a request
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HIT,
        OP_RELEASE,
        OP_APPEND,
        OP_OOM,
        OP_NF
    } t_op;

    typedef logic [3:0] t_step;
    localparam t_step S_IDLE  = 4'd0;
    localparam t_step S_DISP  = 4'd1;
    localparam t_step S_ASCAN = 4'd2;
    localparam t_step S_ADEC  = 4'd3;
    localparam t_step S_AHIT  = 4'd4;
    localparam t_step S_ACHK  = 4'd5;
    localparam t_step S_AOOM  = 4'd6;
    localparam t_step S_AAPP  = 4'd7;
    localparam t_step S_FSCAN = 4'd8;
    localparam t_step S_FDEC  = 4'd9;
    localparam t_step S_FHIT  = 4'd10;
    localparam t_step S_FNF   = 4'd11;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  hold;
        logic  idle;
        logic  idx_inc;
        t_op   op;
    } t_cw;

    typedef struct packed {
        logic free;
        logic scan_end;
        logic fit;
        logic match;
        logic room;
    } t_flags;

    // Control store: one word per step
    function automatic t_cw ucode(t_step s);
        t_cw cw;
        cw = '{cond: C_ALWAYS, target: S_IDLE, hold: 1'b0, idle: 1'b0,
               idx_inc: 1'b0, op: OP_NONE};
        unique case (s)
            S_IDLE: begin
                cw.cond   = C_START;
                cw.target = S_DISP;
                cw.hold   = 1'b1;
                cw.idle   = 1'b1;
            end
            S_DISP: begin
                cw.cond   = C_FREE;
                cw.target = S_FSCAN;
            end
            S_ASCAN: begin
                cw.cond    = C_ASTOP;
                cw.target  = S_ADEC;
                cw.hold    = 1'b1;
                cw.idx_inc = 1'b1;
            end
            S_ADEC: begin
                cw.cond   = C_END;
                cw.target = S_ACHK;
            end
            S_AHIT: cw.op = OP_HIT;
            S_ACHK: begin
                cw.cond   = C_ROOM;
                cw.target = S_AAPP;
            end
            S_AOOM: cw.op = OP_OOM;
            S_AAPP: cw.op = OP_APPEND;
            S_FSCAN: begin
                cw.cond    = C_FSTOP;
                cw.target  = S_FDEC;
                cw.hold    = 1'b1;
                cw.idx_inc = 1'b1;
            end
            S_FDEC: begin
                cw.cond   = C_END;
                cw.target = S_FNF;
            end
            S_FHIT: cw.op = OP_RELEASE;
            S_FNF:  cw.op = OP_NF;
            default: cw.op = OP_NONE;
        endcase
        return cw;
    endfunction

endpackage

// ----- rtl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte pool with an APB-style pool size register.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the answer is ready, and the answer appears for exactly one cycle with
// o_done high, which the receiver must capture since it cannot stall. The
// request walks the block table one entry per cycle through a memory with one
// read port and one write port under a small microcoded sequencer; a request
// stops at the entry it seeks or after all entries in use. The next request
// may be started in the cycle its predecessor's answer is shown.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_req_type,
    input  ffba_pkg::t_addr         i_req_size,
    input  ffba_pkg::t_addr         i_free_offset,
    output logic                    o_done,
    output ffba_pkg::t_addr         o_alloc_offset,
    output ffba_pkg::t_status       o_status,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    ffba_pkg::t_pool  r_pool;
    ffba_pkg::t_cw    cw;
    ffba_pkg::t_flags flags;
    logic             taken;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(ffba_pkg::REG_POOL));
    assign prdata  = reg_sel ? 32'(r_pool) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= ffba_pkg::POOL_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_pool <= pwdata[ffba_pkg::POOL_BITS-1:0];
        end
    end

    assign busy = !cw.idle;

    ffba_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_cw    (cw),
        .o_taken (taken)
    );

    ffba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cw           (cw),
        .i_taken        (taken),
        .i_pool_bytes   (r_pool),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_flags        (flags),
        .o_done         (o_done),
        .o_alloc_offset (o_alloc_offset),
        .o_status       (o_status)
    );

endmodule

// ----- rtl/ffba_seq.sv -----
// ----------------------------------------------------------------------------
// ffba_seq
// Step counter, control store lookup and jump condition select.
// ----------------------------------------------------------------------------
module ffba_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ffba_pkg::t_flags  i_flags,
    output ffba_pkg::t_cw     o_cw,
    output logic              o_taken
);

    ffba_pkg::t_step r_step;
    ffba_pkg::t_step n_step;
    ffba_pkg::t_cw   cw;
    logic            taken;

    assign cw = ffba_pkg::ucode(r_step);

    always_comb begin
        unique case (cw.cond)
            ffba_pkg::C_NEVER:  taken = 1'b0;
            ffba_pkg::C_ALWAYS: taken = 1'b1;
            ffba_pkg::C_START:  taken = i_start;
            ffba_pkg::C_FREE:   taken = i_flags.free;
            ffba_pkg::C_ASTOP:  taken = i_flags.scan_end | i_flags.fit;
            ffba_pkg::C_FSTOP:  taken = i_flags.scan_end | i_flags.match;
            ffba_pkg::C_END:    taken = i_flags.scan_end;
            ffba_pkg::C_ROOM:   taken = i_flags.room;
            default:            taken = 1'b0;
        endcase
    end

    always_comb begin
        if (taken) begin
            n_step = cw.target;
        end else if (cw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + ffba_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ffba_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_cw    = cw;
    assign o_taken = taken;

endmodule

// ----- rtl/ffba_dp.sv -----
// ----------------------------------------------------------------------------
// ffba_dp
// Block table memory, scan index, bump counter and result registers.
// ----------------------------------------------------------------------------
module ffba_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  ffba_pkg::t_cw           i_cw,
    input  logic                    i_taken,
    input  ffba_pkg::t_pool         i_pool_bytes,
    input  logic                    i_req_type,
    input  ffba_pkg::t_addr         i_req_size,
    input  ffba_pkg::t_addr         i_free_offset,
    output ffba_pkg::t_flags        o_flags,
    output logic                    o_done,
    output ffba_pkg::t_addr         o_alloc_offset,
    output ffba_pkg::t_status       o_status
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int GW = ffba_pkg::CONS_BITS + 1;
    localparam ffba_pkg::t_addr HDR       = ffba_pkg::ADDR_BITS'(HEADER_BYTES);
    localparam logic [CW-1:0]   COUNT_MAX = CW'(MAX_BLOCKS);

    typedef struct packed {
        ffba_pkg::t_addr offset;
        ffba_pkg::t_addr length;
        logic            busy;
    } t_entry;

    t_entry mem [MAX_BLOCKS];
    t_entry r_rd;

    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic [CW-1:0]      r_count;
    ffba_pkg::t_cons    r_consumed;
    logic               r_type;
    ffba_pkg::t_addr    r_size;
    ffba_pkg::t_addr    r_target;
    logic               r_done;
    ffba_pkg::t_addr    r_offset;
    ffba_pkg::t_status  r_status;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    t_entry             wr_data;
    ffba_pkg::t_addr    rd_payload;
    ffba_pkg::t_addr    app_payload;
    logic [GW-1:0]      grown;

    // Read address follows the next index so r_rd always holds entry r_idx
    always_comb begin
        if (i_cw.idle) begin
            n_idx = '0;
        end else if (i_cw.idx_inc && !i_taken) begin
            n_idx = r_idx + CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    assign rd_payload  = r_rd.offset + HDR;
    assign app_payload = r_consumed[ffba_pkg::ADDR_BITS-1:0] + HDR;
    assign grown       = {1'b0, r_consumed} + GW'(r_size) + GW'(HEADER_BYTES);

    assign o_flags.free     = (r_type == ffba_pkg::REQ_FREE);
    assign o_flags.scan_end = (r_idx >= r_count);
    assign o_flags.fit      = !r_rd.busy && (r_rd.length >= r_size);
    assign o_flags.match    = (rd_payload == r_target);
    assign o_flags.room     = (r_consumed < {1'b0, i_pool_bytes}) && (r_count < COUNT_MAX);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd;
        case (i_cw.op)
            ffba_pkg::OP_HIT: begin
                wr_en        = 1'b1;
                wr_data.busy = 1'b1;
            end
            ffba_pkg::OP_RELEASE: begin
                wr_en        = 1'b1;
                wr_data.busy = 1'b0;
            end
            ffba_pkg::OP_APPEND: begin
                wr_en          = 1'b1;
                wr_addr        = r_count[AW-1:0];
                wr_data.offset = r_consumed[ffba_pkg::ADDR_BITS-1:0];
                wr_data.length = r_size;
                wr_data.busy   = 1'b1;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[n_idx[AW-1:0]];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_count    <= '0;
            r_consumed <= '0;
            r_done     <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_done <= (i_cw.op != ffba_pkg::OP_NONE);
            if (i_cw.op == ffba_pkg::OP_APPEND) begin
                r_count <= r_count + CW'(1);
                // saturate the bump counter at all ones
                r_consumed <= grown[GW-1] ? '1 : grown[ffba_pkg::CONS_BITS-1:0];
            end
        end
    end

    // Request and result words
    always_ff @(posedge i_clk) begin
        if (i_cw.idle) begin
            r_type   <= i_req_type;
            r_size   <= i_req_size;
            r_target <= i_free_offset;
        end
        case (i_cw.op)
            ffba_pkg::OP_HIT: begin
                r_offset <= rd_payload;
                r_status <= ffba_pkg::ST_OK;
            end
            ffba_pkg::OP_APPEND: begin
                r_offset <= app_payload;
                r_status <= ffba_pkg::ST_OK;
            end
            ffba_pkg::OP_RELEASE: begin
                r_offset <= '0;
                r_status <= ffba_pkg::ST_OK;
            end
            ffba_pkg::OP_OOM: begin
                r_offset <= '0;
                r_status <= ffba_pkg::ST_OOM;
            end
            ffba_pkg::OP_NF: begin
                r_offset <= '0;
                r_status <= ffba_pkg::ST_NOT_FOUND;
            end
            default: begin
                r_offset <= r_offset;
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_alloc_offset = r_offset;
    assign o_status       = r_status;

endmodule
